/* hw/rtl/keyword_substitution_cipher_core_assert.svh */
// ----------------------------------------------------------------------------
// Keyword substitution cipher assertion macros
// Short forms for the concurrent assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_SUBSTITUTION_CIPHER_CORE_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSCC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("kscc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("kscc assertion failed");

`endif

/* hw/rtl/kscc_pkg.sv */
// ----------------------------------------------------------------------------
// Keyword substitution cipher package
// Alphabet constants, lookup table bundle and a one-hot encode helper.
// ----------------------------------------------------------------------------
package kscc_pkg;

  localparam int unsigned AlphaSize = 26;
  localparam int unsigned LtrW      = 5;

  localparam logic [7:0] LowerA = 8'h61;
  localparam logic [7:0] LowerZ = 8'h7a;
  localparam logic [7:0] UpperA = 8'h41;
  localparam logic [7:0] UpperZ = 8'h5a;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  typedef logic [LtrW-1:0] ltr_t;

  // Lookup data derived from the key. rank holds, for each letter, how many
  // letters below it are absent from the key.
  typedef struct packed {
    logic                              valid;
    logic [AlphaSize-1:0]              used;
    logic [AlphaSize-1:0][LtrW-1:0]    rank;
  } tbl_t;

  function automatic ltr_t enc_hot(input logic [AlphaSize-1:0] hot);
    ltr_t r;
    r = '0;
    for (int c = 0; c < AlphaSize; c++) begin
      if (hot[c]) begin
        r = r | ltr_t'(c);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/kscc_key_prep.sv */
// ----------------------------------------------------------------------------
// Keyword substitution cipher key preparation
// Checks the key and derives the letter usage and rank tables in two stages.
// ----------------------------------------------------------------------------
module kscc_key_prep import kscc_pkg::*; #(
  parameter int unsigned KEY_LEN = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [KEY_LEN*LtrW-1:0]  key_i,
  output tbl_t                     tbl_o
);

  logic [AlphaSize-1:0]            used_d, used_q;
  logic                            valid_d, valid_q;
  logic [AlphaSize-1:0][LtrW-1:0]  rank_d, rank_q;
  logic [AlphaSize-1:0]            below;

  always_comb begin
    used_d  = '0;
    valid_d = 1'b1;
    for (int p = 0; p < KEY_LEN; p++) begin
      if (key_i[p*LtrW +: LtrW] >= ltr_t'(AlphaSize)) begin
        valid_d = 1'b0;
      end else begin
        used_d[key_i[p*LtrW +: LtrW]] = 1'b1;
      end
      for (int q = p + 1; q < KEY_LEN; q++) begin
        if (key_i[p*LtrW +: LtrW] == key_i[q*LtrW +: LtrW]) begin
          valid_d = 1'b0;
        end
      end
    end
  end

  // A letter outside the key lands at its own code less the key letters below it.
  always_comb begin
    rank_d = '0;
    below  = '0;
    for (int c = 0; c < AlphaSize; c++) begin
      below     = (AlphaSize'(1) << c) - AlphaSize'(1);
      rank_d[c] = ltr_t'(c) - ltr_t'($countones(below & used_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      used_q  <= used_d;
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  assign tbl_o = '{valid: valid_q, used: used_q, rank: rank_q};

endmodule

/* hw/rtl/kscc_map_pipe.sv */
// ----------------------------------------------------------------------------
// Keyword substitution cipher mapping pipeline
// Three register stages: letter decode, table match, result encode.
// ----------------------------------------------------------------------------
module kscc_map_pipe import kscc_pkg::*; #(
  parameter int unsigned KEY_LEN = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     operation_i,
  input  logic [7:0]               in_char_i,
  input  logic                     in_last_i,
  input  logic [KEY_LEN*LtrW-1:0]  key_i,
  input  tbl_t                     tbl_i,
  output logic                     out_valid_o,
  output logic [7:0]               out_char_o,
  output logic                     out_last_o,
  output logic                     key_invalid_o
);

  localparam logic [LtrW:0] KeyLenW = (LtrW+1)'(KEY_LEN);

  // Stage 1: letter decode.
  logic        s1_vld_q;
  logic        s1_op_q, s1_last_q, s1_ltr_q;
  logic [7:0]  s1_char_q;
  ltr_t        s1_idx_q;
  logic        is_lower, is_upper;

  // Stage 2: table match.
  logic                  s2_vld_q;
  logic                  s2_op_q, s2_last_q, s2_ltr_q;
  logic [7:0]            s2_char_q;
  logic                  from_key_d, s2_from_key_q;
  ltr_t                  key_ltr_d, s2_key_ltr_q;
  logic [AlphaSize-1:0]  hot_d, s2_hot_q;
  logic [KEY_LEN-1:0]    hit_d, s2_hit_q;
  ltr_t                  rank_sel_d, s2_rank_q;
  ltr_t                  rest_pos;

  // Stage 3: result encode.
  ltr_t        enc_res, dec_res, hit_pos, res;
  logic        out_valid_q;
  logic [7:0]  out_char_d, out_char_q;
  logic        out_last_q, key_invalid_q;

  assign is_lower = (in_char_i >= LowerA) && (in_char_i <= LowerZ);
  assign is_upper = (in_char_i >= UpperA) && (in_char_i <= UpperZ);

  always_comb begin
    from_key_d = {1'b0, s1_idx_q} < KeyLenW;
    rest_pos   = s1_idx_q - KeyLenW[LtrW-1:0];
    key_ltr_d  = '0;
    hit_d      = '0;
    for (int p = 0; p < KEY_LEN; p++) begin
      if (s1_idx_q == ltr_t'(p)) begin
        key_ltr_d = key_i[p*LtrW +: LtrW];
      end
      hit_d[p] = (key_i[p*LtrW +: LtrW] == s1_idx_q);
    end
    rank_sel_d = '0;
    hot_d      = '0;
    for (int c = 0; c < AlphaSize; c++) begin
      if (s1_idx_q == ltr_t'(c)) begin
        rank_sel_d = tbl_i.rank[c];
      end
      hot_d[c] = !tbl_i.used[c] && (tbl_i.rank[c] == rest_pos);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int p = 0; p < KEY_LEN; p++) begin
      if (s2_hit_q[p]) begin
        hit_pos = hit_pos | ltr_t'(p);
      end
    end
    enc_res = s2_from_key_q ? s2_key_ltr_q : enc_hot(s2_hot_q);
    dec_res = (|s2_hit_q) ? hit_pos : ltr_t'(s2_rank_q + KeyLenW[LtrW-1:0]);
    res     = (s2_op_q == OpDecrypt) ? dec_res : enc_res;
    if (tbl_i.valid && s2_ltr_q) begin
      out_char_d = LowerA + 8'(res);
    end else begin
      out_char_d = s2_char_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      out_valid_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q       <= operation_i;
    s1_char_q     <= in_char_i;
    s1_last_q     <= in_last_i;
    s1_ltr_q      <= is_lower || is_upper;
    s1_idx_q      <= is_upper ? ltr_t'(in_char_i - UpperA) : ltr_t'(in_char_i - LowerA);
    s2_op_q       <= s1_op_q;
    s2_char_q     <= s1_char_q;
    s2_last_q     <= s1_last_q;
    s2_ltr_q      <= s1_ltr_q;
    s2_from_key_q <= from_key_d;
    s2_key_ltr_q  <= key_ltr_d;
    s2_hot_q      <= hot_d;
    s2_hit_q      <= hit_d;
    s2_rank_q     <= rank_sel_d;
    out_char_q    <= out_char_d;
    out_last_q    <= s2_last_q;
    key_invalid_q <= !tbl_i.valid;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign out_last_o    = out_last_q;
  assign key_invalid_o = key_invalid_q;

endmodule

/* hw/rtl/keyword_substitution_cipher_core.sv */
// ----------------------------------------------------------------------------
// Keyword substitution cipher core
// Maps one text byte per cycle, while busy is low, through a keyword-built cipher alphabet.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  input     start high, busy low         operation_i, in_char_i, in_last_i
//  result    out_valid_o, single cycle    out_char_o, out_last_o, key_invalid_o
//  config    cfg_valid_i and cfg_ready_o  cfg_data_i (key letters)
//
// A byte accepted at a clock edge passes the decode, match and encode stage
// registers of the mapping pipeline before it reaches the result ports; one
// byte can be taken every cycle while busy is low.
// busy is high for the first cycle after reset and for one cycle after a key
// transfer. The receiver cannot stall.
module keyword_substitution_cipher_core import kscc_pkg::*; #(
  parameter int unsigned KEY_LEN = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     operation_i,
  input  logic [7:0]               in_char_i,
  input  logic                     in_last_i,
  output logic                     out_valid_o,
  output logic [7:0]               out_char_o,
  output logic                     out_last_o,
  output logic                     key_invalid_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [KEY_LEN*LtrW-1:0]  cfg_data_i
);

  localparam int unsigned         KeyW     = KEY_LEN * LtrW;
  localparam logic [KeyW-1:0]     ResetKey = KeyW'(64'd4294688);

  logic [KeyW-1:0]  key_d, key_q, key_eff;
  logic             refresh_d, refresh_q;
  logic             cfg_write;
  tbl_t             tbl;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign key_d       = cfg_write ? cfg_data_i : key_q;
  assign refresh_d   = cfg_write;
  assign busy        = refresh_q;

  // Only the low 64 key bits are used; letters reaching past them read as zero.
  always_comb begin
    key_eff = '0;
    for (int j = 0; j < KeyW; j++) begin
      if (j < 64) begin
        key_eff[j] = key_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= ResetKey;
      refresh_q <= 1'b1;
    end else begin
      key_q     <= key_d;
      refresh_q <= refresh_d;
    end
  end

  kscc_key_prep #(
    .KEY_LEN (KEY_LEN)
  ) u_key_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_eff),
    .tbl_o  (tbl)
  );

  kscc_map_pipe #(
    .KEY_LEN (KEY_LEN)
  ) u_map_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (start && !busy),
    .operation_i   (operation_i),
    .in_char_i     (in_char_i),
    .in_last_i     (in_last_i),
    .key_i         (key_eff),
    .tbl_i         (tbl),
    .out_valid_o   (out_valid_o),
    .out_char_o    (out_char_o),
    .out_last_o    (out_last_o),
    .key_invalid_o (key_invalid_o)
  );

endmodule

/* hw/rtl/kscc_checker.sv */
// ----------------------------------------------------------------------------
// Keyword substitution cipher checker
// Port-level assertions on latency, last flag, pass-through and result range.
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_core_assert.svh"

module kscc_checker import kscc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  in_char_i,
  input  logic        in_last_i,
  input  logic        out_valid_o,
  input  logic [7:0]  out_char_o,
  input  logic        out_last_o,
  input  logic        key_invalid_o
);

  logic acc;
  logic is_ltr;
  logic out_lower;

  assign acc       = start && !busy;
  assign is_ltr    = ((in_char_i >= LowerA) && (in_char_i <= LowerZ)) ||
                     ((in_char_i >= UpperA) && (in_char_i <= UpperZ));
  assign out_lower = (out_char_o >= LowerA) && (out_char_o <= LowerZ);

  // Every transfer in gives exactly one result out of the mapping pipeline.
  `KSCC_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, rst_ni && $past(rst_ni) && $past(rst_ni, 2) && $past(acc, 2), out_valid_o)
  `KSCC_ASSERT_IMPL(a_no_spurious, clk_i, rst_ni, out_valid_o, $past(acc, 3))
  `KSCC_ASSERT_IMPL(a_last_kept, clk_i, rst_ni, out_valid_o, out_last_o == $past(in_last_i, 3))
  `KSCC_ASSERT_IMPL(a_pass_through, clk_i, rst_ni, out_valid_o && !$past(is_ltr, 3), out_char_o == $past(in_char_i, 3))
  `KSCC_ASSERT_IMPL(a_lower_result, clk_i, rst_ni, out_valid_o && !key_invalid_o && $past(is_ltr, 3), out_lower)

endmodule

bind keyword_substitution_cipher_core kscc_checker u_kscc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .in_char_i     (in_char_i),
  .in_last_i     (in_last_i),
  .out_valid_o   (out_valid_o),
  .out_char_o    (out_char_o),
  .out_last_o    (out_last_o),
  .key_invalid_o (key_invalid_o)
);
